[rtl/dplru_pkg.sv]
// Package: constants, status codes and opcodes for the demand-paging LRU frame unit.
`default_nettype none

package dplru_pkg;

    // Geometry of the paging unit
    localparam int LINES_PER_PAGE    = 4;
    localparam int FRAME_COUNT       = 8;
    localparam int NUM_PROGRAMS      = 4;
    localparam int PAGES_PER_PROGRAM = 32;

    localparam int OFS_W     = $clog2(LINES_PER_PAGE);
    localparam int FRAME_W   = $clog2(FRAME_COUNT);
    localparam int PROG_W    = $clog2(NUM_PROGRAMS);
    localparam int PAGE_W    = $clog2(PAGES_PER_PROGRAM);
    localparam int MAP_DEPTH = NUM_PROGRAMS * PAGES_PER_PROGRAM;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int STAMP_W   = 64;

    // Field widths of the stream words
    localparam int LINE_W  = 7;
    localparam int PLINE_W = 8;
    localparam int SLOT_W  = 5;

    // Result status codes
    typedef enum logic [2:0] {
        ST_HIT         = 3'd0,
        ST_FAULT_FREE  = 3'd1,
        ST_FAULT_EVICT = 3'd2,
        ST_RANGE       = 3'd3,
        ST_NO_FREE     = 3'd4,
        ST_PRESENT     = 3'd5
    } status_t;

    // Request kinds
    typedef enum logic {
        OP_ACCESS  = 1'b0,
        OP_PRELOAD = 1'b1
    } op_t;

endpackage

`default_nettype wire

[rtl/demand_paging_lru_frames.sv]
// Top level: demand-paging unit with per-program page table and LRU frame replacement.
//
// Each input word is a line access or a page preload; each produces exactly one result
// word. An out-of-range request, a hit or a preload of a mapped page takes its result
// from the lookup state, after the page-table read that is registered at acceptance. A
// miss, or a preload that needs a frame, goes on from the lookup state to a scan: the
// frame table is scanned one frame per cycle through a single 64-bit stamp comparator
// (8 frames), which finds the lowest free frame and the least recently used frame, then
// the fill state fills the chosen frame (a preload finding no free frame fills none).
// A new word is taken only once the unit is idle again, so no word is taken before the
// last one is through. A finished result sits in the output register while the next
// word is worked on; the decision or fill cycle of that next word waits while the
// previous result has not been taken. The page table is a memory with registered read;
// its valid bits are flip-flops cleared at reset, so no clearing pass is needed.
`default_nettype none

module demand_paging_lru_frames (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // program_id[1:0], line_no[8:2],
                                        // page_number[13:9], program_lines[21:14]
    input  wire logic [0:0]  s_tuser,   // opcode[0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // frame_index[2:0], slot_address[7:3],
                                        // evict_prog[9:8], evict_page[14:10]
    output logic [2:0]       m_tuser    // status[2:0]
);
    import dplru_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOKUP = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FILL   = 4'b1000
    } state_t;

    state_t state_reg;

    // input word fields
    op_t                in_op;
    logic [PROG_W-1:0]  in_prog;
    logic [LINE_W-1:0]  in_line;
    logic [PAGE_W-1:0]  in_pnum;
    logic [PLINE_W-1:0] in_plines;
    logic [PLINE_W:0]   in_npages;
    logic [PAGE_W-1:0]  in_page;
    logic               in_range_bad;
    logic [MAP_AW-1:0]  in_map_addr;
    logic               s_accept;

    // request registers
    op_t               op_reg;
    logic [PROG_W-1:0] prog_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [OFS_W-1:0]  offs_reg;
    logic              range_bad_reg;

    // page table: frame memory plus valid flops
    logic [FRAME_W-1:0] map_mem [MAP_DEPTH];
    logic [MAP_DEPTH-1:0] map_valid_reg;
    logic [MAP_DEPTH-1:0] map_valid_next;
    logic [FRAME_W-1:0] map_frame_reg;
    logic               map_hit_reg;
    logic               map_wr_en;
    logic [FRAME_W-1:0] fill_idx;

    // frame table
    logic [FRAME_COUNT-1:0] frame_busy_reg;
    logic [PROG_W-1:0]      frame_owner_reg [FRAME_COUNT];
    logic [PAGE_W-1:0]      frame_page_reg  [FRAME_COUNT];
    logic [STAMP_W-1:0]     frame_stamp_reg [FRAME_COUNT];
    logic [STAMP_W-1:0]     use_clock_reg;
    logic [STAMP_W-1:0]     use_clock_next;

    // scan registers
    logic [FRAME_W-1:0] scan_idx_reg;
    logic               free_found_reg;
    logic [FRAME_W-1:0] free_idx_reg;
    logic [STAMP_W-1:0] best_stamp_reg;
    logic [FRAME_W-1:0] best_idx_reg;
    logic [PROG_W-1:0]  best_owner_reg;
    logic [PAGE_W-1:0]  best_page_reg;
    logic               scan_older;

    // result registers
    logic               m_tvalid_reg;
    status_t            m_status_reg;
    logic [FRAME_W-1:0] m_frame_reg;
    logic [SLOT_W-1:0]  m_slot_reg;
    logic [PROG_W-1:0]  m_vprog_reg;
    logic [PAGE_W-1:0]  m_vpage_reg;
    logic               out_free;
    logic               res_load;

    // result of the current step
    logic               res_valid;
    status_t            res_status;
    logic [FRAME_W-1:0] res_frame;
    logic [SLOT_W-1:0]  res_slot;
    logic [PROG_W-1:0]  res_vprog;
    logic [PAGE_W-1:0]  res_vpage;

    // unpack and range-check the incoming word
    assign in_op     = op_t'(s_tuser[0]);
    assign in_prog   = s_tdata[1:0];
    assign in_line   = s_tdata[8:2];
    assign in_pnum   = s_tdata[13:9];
    assign in_plines = s_tdata[21:14];
    assign in_npages = ({1'b0, in_plines} + (PLINE_W+1)'(LINES_PER_PAGE - 1)) >> OFS_W;
    assign in_page   = (in_op == OP_PRELOAD) ? in_pnum : PAGE_W'(in_line >> OFS_W);

    always_comb begin
        if (in_op == OP_PRELOAD) begin
            in_range_bad = ((PLINE_W+1)'(in_pnum) >= in_npages);
        end else begin
            in_range_bad = ({1'b0, in_line} >= in_plines);
        end
    end

    assign in_map_addr = {in_prog, in_page};
    assign s_tready    = (state_reg == S_IDLE);
    assign s_accept    = s_tvalid && s_tready;

    // output register can take a new result this cycle
    assign out_free = !m_tvalid_reg || m_tready;
    assign res_load = res_valid && out_free;

    assign use_clock_next = use_clock_reg + STAMP_W'(1);
    assign scan_older     = (frame_stamp_reg[scan_idx_reg] < best_stamp_reg);
    assign fill_idx       = free_found_reg ? free_idx_reg : best_idx_reg;
    assign map_wr_en      = (state_reg == S_FILL) && out_free
                            && (free_found_reg || op_reg == OP_ACCESS);

    // valid bits after a fill: drop the victim's mapping, then map the new page
    always_comb begin
        map_valid_next = map_valid_reg;
        if (!free_found_reg) begin
            map_valid_next[{best_owner_reg, best_page_reg}] = 1'b0;
        end
        map_valid_next[{prog_reg, page_reg}] = 1'b1;
    end

    // page-table memory: registered read at accept, write on fill
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            map_frame_reg <= map_mem[in_map_addr];
        end
        if (map_wr_en) begin
            map_mem[{prog_reg, page_reg}] <= fill_idx;
        end
    end

    // result selection for the decision states
    always_comb begin
        res_valid  = 1'b0;
        res_status = ST_RANGE;
        res_frame  = '0;
        res_slot   = '0;
        res_vprog  = '0;
        res_vpage  = '0;
        unique case (state_reg)
            S_LOOKUP: begin
                if (range_bad_reg) begin
                    res_valid  = 1'b1;
                    res_status = ST_RANGE;
                end else if (map_hit_reg) begin
                    res_valid = 1'b1;
                    res_frame = map_frame_reg;
                    if (op_reg == OP_PRELOAD) begin
                        res_status = ST_PRESENT;
                    end else begin
                        res_status = ST_HIT;
                        res_slot   = {map_frame_reg, offs_reg};
                    end
                end
            end
            S_FILL: begin
                res_valid = 1'b1;
                if (free_found_reg) begin
                    res_status = ST_FAULT_FREE;
                    res_frame  = free_idx_reg;
                end else if (op_reg == OP_PRELOAD) begin
                    res_status = ST_NO_FREE;
                end else begin
                    res_status = ST_FAULT_EVICT;
                    res_frame  = best_idx_reg;
                    res_vprog  = best_owner_reg;
                    res_vpage  = best_page_reg;
                end
            end
            S_IDLE, S_SCAN: begin
                res_valid = 1'b0;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    // sequencer, frame table and page-table valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            map_valid_reg  <= '0;
            frame_busy_reg <= '0;
            use_clock_reg  <= '0;
            free_found_reg <= 1'b0;
            scan_idx_reg   <= '0;
            map_hit_reg    <= 1'b0;
            for (int i = 0; i < FRAME_COUNT; i++) begin
                frame_owner_reg[i] <= '0;
                frame_page_reg[i]  <= '0;
                frame_stamp_reg[i] <= '0;
            end
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        op_reg        <= in_op;
                        prog_reg      <= in_prog;
                        page_reg      <= in_page;
                        offs_reg      <= in_line[OFS_W-1:0];
                        range_bad_reg <= in_range_bad;
                        map_hit_reg   <= map_valid_reg[in_map_addr];
                        state_reg     <= S_LOOKUP;
                    end
                end
                S_LOOKUP: begin
                    if (range_bad_reg) begin
                        if (out_free) begin
                            state_reg <= S_IDLE;
                        end
                    end else if (map_hit_reg) begin
                        // hit refreshes the stamp; a preload leaves it alone
                        if (out_free) begin
                            if (op_reg == OP_ACCESS) begin
                                use_clock_reg                  <= use_clock_next;
                                frame_stamp_reg[map_frame_reg] <= use_clock_next;
                            end
                            state_reg <= S_IDLE;
                        end
                    end else begin
                        scan_idx_reg   <= '0;
                        free_found_reg <= 1'b0;
                        state_reg      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // lowest free frame
                    if (!frame_busy_reg[scan_idx_reg] && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= scan_idx_reg;
                    end
                    // oldest stamp, lower index wins ties
                    if (scan_idx_reg == '0 || scan_older) begin
                        best_stamp_reg <= frame_stamp_reg[scan_idx_reg];
                        best_idx_reg   <= scan_idx_reg;
                        best_owner_reg <= frame_owner_reg[scan_idx_reg];
                        best_page_reg  <= frame_page_reg[scan_idx_reg];
                    end
                    if (scan_idx_reg == FRAME_W'(FRAME_COUNT - 1)) begin
                        state_reg <= S_FILL;
                    end else begin
                        scan_idx_reg <= scan_idx_reg + FRAME_W'(1);
                    end
                end
                S_FILL: begin
                    if (out_free) begin
                        if (map_wr_en) begin
                            map_valid_reg             <= map_valid_next;
                            frame_busy_reg[fill_idx]  <= 1'b1;
                            frame_owner_reg[fill_idx] <= prog_reg;
                            frame_page_reg[fill_idx]  <= page_reg;
                            frame_stamp_reg[fill_idx] <= use_clock_next;
                            use_clock_reg             <= use_clock_next;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_status_reg <= res_status;
            m_frame_reg  <= res_frame;
            m_slot_reg   <= res_slot;
            m_vprog_reg  <= res_vprog;
            m_vpage_reg  <= res_vpage;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {1'b0, m_vpage_reg, m_vprog_reg, m_slot_reg, m_frame_reg};

    // checks
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result word changed while waiting");

    a_accept_to_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == S_LOOKUP)
        else $error("accepted word did not start a lookup");

    a_clock_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (use_clock_reg == $past(use_clock_reg)
               || use_clock_reg == $past(use_clock_reg) + STAMP_W'(1)))
        else $error("use clock moved by more than one");

    a_victim_only_on_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_status_reg != ST_FAULT_EVICT)
            |-> (m_vprog_reg == '0 && m_vpage_reg == '0))
        else $error("victim reported without eviction");

    a_hit_frame_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (res_status == ST_HIT || res_status == ST_PRESENT))
            |-> frame_busy_reg[res_frame])
        else $error("page table points at a free frame");

endmodule

`default_nettype wire
